// ----- hdl/sector_chain_walker_assert.svh -----
// assertion macros for the sector chain walker
// used by sector_chain_walker.sv; expects i_clk and i_rst_n in scope
`ifndef SECTOR_CHAIN_WALKER_ASSERT_SVH
`define SECTOR_CHAIN_WALKER_ASSERT_SVH

`ifndef SYNTH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define SCW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sector chain walker check failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define SCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sector chain walker check failed");

`else

`define SCW_ASSERT_IMPLY(lbl, ante, cons)
`define SCW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/scw_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sector chain walker
// no dependencies; used by scw_sector_check and sector_chain_walker
package scw_pkg;

    // link table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // field and register widths
    localparam int LINK_W      = 32;
    localparam int INDEX_W     = 5;
    localparam int MAX_ID_W    = 5;
    localparam int RECORDS_W   = 6;
    localparam int SIZE_W      = 13;
    localparam int OFFSET_W    = 25;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = MAX_ID_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SIZE_W;

    // full offset before truncation, wide enough for sector * size + bias
    localparam int PROD_W      = ADDR_W + SIZE_W + 1;
    localparam int FULL_OFF_W  = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;

    localparam int HEADER_BIAS = 512;

    // register reset values
    localparam logic [MAX_ID_W-1:0]  MAX_ID_RST  = MAX_ID_W'(31);
    localparam logic [RECORDS_W-1:0] RECORDS_RST = RECORDS_W'(32);
    localparam logic [SIZE_W-1:0]    SIZE_RST    = SIZE_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ID  = 2'd0,
        CFG_RECORDS = 2'd1,
        CFG_SIZE    = 2'd2,
        CFG_SHORT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_NEG   = 3'd1,
        ST_LIMIT = 3'd2,
        ST_LONG  = 3'd3,
        ST_LOOP  = 3'd4
    } t_status;

    typedef struct packed {
        logic [MAX_ID_W-1:0]  max_id;
        logic [RECORDS_W-1:0] records;
        logic [SIZE_W-1:0]    size;
        logic                 short_off;
    } t_cfg;

    typedef struct packed {
        t_status               status;
        logic [ADDR_W-1:0]     addr;
        logic [FULL_OFF_W-1:0] off;
    } t_eval;

endpackage

// ----- hdl/scw_sector_check.sv -----
`timescale 1ns / 1ps
// per-sector checks and byte offset for one step of a chain walk
// depends on scw_pkg
module scw_sector_check (
    input  logic signed [scw_pkg::LINK_W-1:0]     i_sector,
    input  scw_pkg::t_cfg                         i_cfg,
    input  logic        [scw_pkg::FULL_OFF_W-1:0] i_prev_off,
    input  logic                                  i_prev_valid,
    input  logic        [scw_pkg::COUNT_W-1:0]    i_count,
    output scw_pkg::t_eval                        o_eval
);

    logic [scw_pkg::LINK_W-1:0]     sec_u;
    logic                           over_depth;
    logic                           over_limit;
    logic [scw_pkg::FULL_OFF_W-1:0] prod;
    logic [scw_pkg::FULL_OFF_W-1:0] full_off;

    assign sec_u      = unsigned'(i_sector);
    assign over_depth = sec_u >= scw_pkg::LINK_W'(scw_pkg::TABLE_DEPTH);
    assign over_limit = (sec_u > scw_pkg::LINK_W'(i_cfg.max_id))
                     && (sec_u >= scw_pkg::LINK_W'(i_cfg.records));

    // sector id is below the table depth whenever the offset is used
    assign prod = scw_pkg::FULL_OFF_W'(sec_u[scw_pkg::ADDR_W-1:0])
                * scw_pkg::FULL_OFF_W'(i_cfg.size);
    assign full_off = i_cfg.short_off ? prod
                    : prod + scw_pkg::FULL_OFF_W'(scw_pkg::HEADER_BIAS);

    always_comb begin
        o_eval.addr = sec_u[scw_pkg::ADDR_W-1:0];
        o_eval.off  = full_off;
        if (i_sector < 0) begin
            o_eval.status = scw_pkg::ST_NEG;
        end else if (over_depth || over_limit) begin
            o_eval.status = scw_pkg::ST_LIMIT;
        end else if (i_count > scw_pkg::COUNT_W'(i_cfg.max_id)) begin
            o_eval.status = scw_pkg::ST_LONG;
        end else if (i_prev_valid && (full_off == i_prev_off)) begin
            o_eval.status = scw_pkg::ST_LOOP;
        end else begin
            o_eval.status = scw_pkg::ST_OK;
        end
    end

endmodule

// ----- hdl/sector_chain_walker.sv -----
`timescale 1ns / 1ps
// sector chain walker: link table in a one-port-write, one-read synchronous ram
// write items never raise busy; a walk item raises busy
// each chain sector passes a check state (check + table read), then an emit state;
// an error result comes in the cycle after its check
// the receiver cannot stall; results appear one cycle each on o_result_strobe
// synchronous active-low reset clears control state and config; table stays undefined
module sector_chain_walker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command side
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_mode,
    input  logic        [scw_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic signed [scw_pkg::LINK_W-1:0]     i_entry_value,
    input  logic signed [scw_pkg::LINK_W-1:0]     i_first_sector,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic        [scw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [scw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // results
    output logic                                  o_result_strobe,
    output logic        [scw_pkg::OFFSET_W-1:0]   o_offset,
    output logic                                  o_offset_valid,
    output logic        [scw_pkg::STATUS_W-1:0]   o_status,
    output logic                                  o_last
);

    `include "sector_chain_walker_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    scw_pkg::t_cfg r_cfg;

    // walk context
    logic signed [scw_pkg::LINK_W-1:0]     r_sector;
    logic        [scw_pkg::FULL_OFF_W-1:0] r_prev_off;
    logic                                  r_prev_valid;
    logic        [scw_pkg::FULL_OFF_W-1:0] r_cur_off;
    logic        [scw_pkg::COUNT_W-1:0]    r_count;

    // link table and its registered read port
    logic [scw_pkg::LINK_W-1:0] r_link_mem [scw_pkg::TABLE_DEPTH];
    logic [scw_pkg::LINK_W-1:0] r_rd_data;

    scw_pkg::t_eval eval;
    logic           accept;
    logic           n_mem_we;
    logic           n_mem_re;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // write items land directly; entry index beyond the table is dropped
    assign n_mem_we = accept && !i_mode
                   && (32'(i_entry_index) < 32'(scw_pkg::TABLE_DEPTH));
    // table read is issued only for a sector that passed every check
    assign n_mem_re = (r_state == S_CHECK) && (eval.status == scw_pkg::ST_OK);

    scw_sector_check u_check (
        .i_sector     (r_sector),
        .i_cfg        (r_cfg),
        .i_prev_off   (r_prev_off),
        .i_prev_valid (r_prev_valid),
        .i_count      (r_count),
        .o_eval       (eval)
    );

    // link table: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            r_link_mem[i_entry_index[scw_pkg::ADDR_W-1:0]] <= i_entry_value;
        end
        if (n_mem_re) begin
            r_rd_data <= r_link_mem[eval.addr];
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_id    <= scw_pkg::MAX_ID_RST;
            r_cfg.records   <= scw_pkg::RECORDS_RST;
            r_cfg.size      <= scw_pkg::SIZE_RST;
            r_cfg.short_off <= 1'b0;
        end else if (i_cfg_we) begin
            case (scw_pkg::t_cfg_idx'(i_cfg_index))
                scw_pkg::CFG_MAX_ID:  r_cfg.max_id    <= i_cfg_data[scw_pkg::MAX_ID_W-1:0];
                scw_pkg::CFG_RECORDS: r_cfg.records   <= i_cfg_data[scw_pkg::RECORDS_W-1:0];
                scw_pkg::CFG_SIZE:    r_cfg.size      <= i_cfg_data[scw_pkg::SIZE_W-1:0];
                scw_pkg::CFG_SHORT:   r_cfg.short_off <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // walk sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_prev_valid    <= 1'b0;
            r_count         <= '0;
            r_sector        <= '0;
            o_result_strobe <= 1'b0;
            o_offset        <= '0;
            o_offset_valid  <= 1'b0;
            o_status        <= scw_pkg::ST_OK;
            o_last          <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_mode) begin
                        // new walk: forget the previous offset and the link count
                        r_sector     <= i_first_sector;
                        r_prev_valid <= 1'b0;
                        r_count      <= '0;
                        r_state      <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (eval.status != scw_pkg::ST_OK) begin
                        // error ends the walk with a status item
                        o_result_strobe <= 1'b1;
                        o_offset        <= '0;
                        o_offset_valid  <= 1'b0;
                        o_status        <= eval.status;
                        o_last          <= 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        // table read is in flight, keep the offset for the emit cycle
                        r_cur_off <= eval.off;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_result_strobe <= 1'b1;
                    o_offset        <= r_cur_off[scw_pkg::OFFSET_W-1:0];
                    o_offset_valid  <= 1'b1;
                    o_status        <= scw_pkg::ST_OK;
                    // a negative link closes the chain normally
                    o_last          <= r_rd_data[scw_pkg::LINK_W-1];
                    r_prev_off      <= r_cur_off;
                    r_prev_valid    <= 1'b1;
                    r_count         <= r_count + 1'b1;
                    r_sector        <= r_rd_data;
                    if (r_rd_data[scw_pkg::LINK_W-1]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // status items carry an error code and always close the walk
    `SCW_ASSERT_IMPLY(a_status_item, o_result_strobe && !o_offset_valid, o_last && (o_status != scw_pkg::ST_OK))
    // sector items never carry an error code
    `SCW_ASSERT_IMPLY(a_sector_ok, o_result_strobe && o_offset_valid, o_status == scw_pkg::ST_OK)
    // the final item of a walk arrives just as the block frees up
    `SCW_ASSERT_IMPLY(a_last_idle, o_result_strobe && o_last, !busy)
    // an item that is not last means the walk is still going
    `SCW_ASSERT_IMPLY(a_more_busy, o_result_strobe && !o_last, busy)
    // an accepted walk item holds the block busy in the next cycle
    `SCW_ASSERT_NEXT(a_walk_busy, start && !busy && i_mode, busy)

endmodule

// ----- tb/sv/tb_sector_chain_walker.sv -----
`timescale 1ns / 1ps
// self-checking bench for sector_chain_walker: builds link chains, walks them under
// several register settings and checks every offset and status item in order
// depends on scw_pkg and the sector_chain_walker rtl only
module tb_sector_chain_walker;
    import scw_pkg::*;

    // one result item as the block should present it
    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic                valid;
        t_status             status;
        logic                last;
    } t_chain_item;

    // mirrors the link table and registers, and holds the chain items still owed
    class offset_ledger;
        logic [LINK_W-1:0] links [TABLE_DEPTH];
        int                max_id;
        int                records;
        int                size_bytes;
        bit                short_off;
        t_chain_item       pending [$];
        int                mismatches;

        function new();
            max_id     = 31;
            records    = 32;
            size_bytes = 512;
            short_off  = 0;
            mismatches = 0;
            foreach (links[k]) links[k] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_ID:  max_id = int'(data[MAX_ID_W-1:0]);
                CFG_RECORDS: records = int'(data[RECORDS_W-1:0]);
                CFG_SIZE:    size_bytes = int'(data);
                CFG_SHORT:   short_off = data[0];
                default: ;
            endcase
        endfunction

        function void owe(logic [OFFSET_W-1:0] off, logic valid, t_status st, logic last);
            t_chain_item c;
            c.offset = off;
            c.valid  = valid;
            c.status = st;
            c.last   = last;
            pending = {pending, c};
        endfunction

        // table writes only update the mirror; a walk queues every item it will give
        function void note_item(logic mode, logic [INDEX_W-1:0] idx,
                                logic [LINK_W-1:0] value, logic [LINK_W-1:0] first);
            longint sec;
            longint nxt;
            longint off;
            longint prev_off;
            bit     prev_ok;
            bit     done;
            int     walked;
            if (!mode) begin
                links[idx] = value;
                return;
            end
            sec      = longint'($signed(first));
            prev_ok  = 0;
            prev_off = 0;
            walked   = 0;
            done     = 0;
            while (!done) begin
                done = 1;
                if (sec < 0) begin
                    owe('0, 1'b0, ST_NEG, 1'b1);
                end else if (sec >= TABLE_DEPTH || (sec > max_id && sec >= records)) begin
                    owe('0, 1'b0, ST_LIMIT, 1'b1);
                end else if (walked > max_id) begin
                    owe('0, 1'b0, ST_LONG, 1'b1);
                end else begin
                    off = sec * size_bytes + (short_off ? 0 : HEADER_BIAS);
                    if (prev_ok && off == prev_off) begin
                        owe('0, 1'b0, ST_LOOP, 1'b1);
                    end else begin
                        nxt = longint'($signed(links[sec]));
                        owe(OFFSET_W'(off), 1'b1, ST_OK, nxt < 0);
                        walked++;
                        prev_off = off;
                        prev_ok  = 1;
                        if (nxt >= 0) begin
                            sec  = nxt;
                            done = 0;
                        end
                    end
                end
            end
        endfunction

        function void check_result(logic [OFFSET_W-1:0] off, logic valid,
                                   logic [STATUS_W-1:0] st, logic last);
            t_chain_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: off=%0d valid=%0b status=%0d last=%0b",
                             off, valid, st, last);
                return;
            end
            want = pending.pop_front();
            if (off !== want.offset || valid !== want.valid ||
                st !== want.status || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("item mismatch: exp off=%0d valid=%0b status=%0d last=%0b, got off=%0d valid=%0b status=%0d last=%0b",
                             want.offset, want.valid, want.status, want.last,
                             off, valid, st, last);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_mode;
    logic [INDEX_W-1:0]      i_entry_index;
    logic signed [LINK_W-1:0] i_entry_value;
    logic signed [LINK_W-1:0] i_first_sector;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    o_result_strobe;
    logic [OFFSET_W-1:0]     o_offset;
    logic                    o_offset_valid;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_last;

    offset_ledger ledger = new();
    int           items_sent = 0;
    bit           steady = 0;   // when set, items go back to back with no gaps

    sector_chain_walker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_first_sector  (i_first_sector),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_offset        (o_offset),
        .o_offset_valid  (o_offset_valid),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // outputs are sampled at the rising edge, before the block updates them
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe === 1'b1)
            ledger.check_result(o_offset, o_offset_valid, o_status, o_last);
    end

    // hand one item to the block; called and returning just after a falling edge
    // start stays high afterwards so a gapless next item needs no toggle
    task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                             input logic [LINK_W-1:0] value,
                             input logic [LINK_W-1:0] first);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= mode;
        i_entry_index  <= idx;
        i_entry_value  <= value;
        i_first_sector <= first;
        // accepted at the first rising edge with busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_item(mode, idx, value, first);
        items_sent++;
        // flip between gapped and gapless stretches now and then
        if ($urandom_range(0, 29) == 0)
            steady = !steady;
        @(negedge i_clk);
    endtask

    // drop start, let every owed item come out, then add idle slack
    task automatic settle();
        start <= 1'b0;
        while (ledger.pending.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // write all four registers back to back while the block is idle
    task automatic apply_setting(input int max_id, input int records,
                                 input int size_bytes, input int short_off);
        int vals [4];
        vals = '{max_id, records, size_bytes, short_off};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= CFG_DATA_W'(vals[k]);
            @(negedge i_clk);
            ledger.set_reg(t_cfg_idx'(k), CFG_DATA_W'(vals[k]));
        end
        i_cfg_we <= 1'b0;
    endtask

    // highest id that passes the limit check under the current registers
    function automatic int valid_top();
        int hi;
        hi = (ledger.max_id > ledger.records - 1) ? ledger.max_id : ledger.records - 1;
        return (hi > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : hi;
    endfunction

    // well-formed chain: link a run of valid ids, pick how it ends, then walk it
    task automatic run_chain();
        int                 len;
        int                 hi;
        int                 cand;
        int                 kind;
        logic [LINK_W-1:0]  tail;
        logic [INDEX_W-1:0] ids [$];
        hi  = valid_top();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            // no accidental self link inside the chain body
            do cand = $urandom_range(0, hi);
            while (k > 0 && hi > 0 && cand == int'(ids[k-1]));
            ids = {ids, INDEX_W'(cand)};
        end
        kind = $urandom_range(0, 11);
        if (kind < 7)
            tail = {1'b1, 31'($urandom)};          // normal end of chain
        else if (kind == 7)
            tail = LINK_W'(ids[len-1]);            // self loop
        else if (kind == 8)
            tail = LINK_W'(ids[0]);                // cycle, ends as too long unless a repeated offset ends it first
        else if (kind == 9)
            tail = {1'b0, 31'($urandom)};          // huge link, beyond limit
        else
            tail = LINK_W'($urandom_range(0, 40)); // small link, maybe tolerated
        for (int k = 0; k < len - 1; k++)
            send_item(1'b0, ids[k], LINK_W'(ids[k+1]), $urandom);
        send_item(1'b0, ids[len-1], tail, $urandom);
        send_item(1'b1, INDEX_W'($urandom), $urandom, LINK_W'(ids[0]));
    endtask

    // short directed run under reset settings; only written entries are ever read
    task automatic directed_walks();
        send_item(1'b0, INDEX_W'(0), 32'd1, 32'd0);
        send_item(1'b0, INDEX_W'(1), 32'd2, 32'd0);
        send_item(1'b0, INDEX_W'(2), 32'hFFFF_FFFF, 32'd0);
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd0);            // three links, last on the third
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'hFFFF_FFFF);    // negative first sector
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'h8000_0000);    // most negative first sector
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'h7FFF_FFFF);    // far beyond the table
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd32);           // just past the table
        send_item(1'b0, INDEX_W'(3), 32'd3, 32'd0);
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd3);            // link points to itself
        send_item(1'b0, INDEX_W'(4), 32'h7FFF_FFFF, 32'd0);
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd4);            // link runs beyond the table
        send_item(1'b0, INDEX_W'(5), 32'h8000_0000, 32'd0);
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd5);            // single sector, end marker
        send_item(1'b0, INDEX_W'(31), 32'd0, 32'd0);
        send_item(1'b1, INDEX_W'(31), 32'd0, 32'd31);          // top id into the first chain
        send_item(1'b0, INDEX_W'(6), 32'd7, 32'd0);
        send_item(1'b0, INDEX_W'(7), 32'd6, 32'd0);
        send_item(1'b1, INDEX_W'(0), 32'd0, 32'd6);            // two-entry cycle, longest walk
    endtask

    initial begin
        int quota;
        int pick;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = 1'b0;
        i_entry_index  = '0;
        i_entry_value  = '0;
        i_first_sector = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_walks();
        settle();

        // every entry gets written before random walks may read it
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_item(1'b0, INDEX_W'(k),
                      ($urandom_range(0, 3) == 0) ? $urandom :
                      LINK_W'($urandom_range(0, 31)), $urandom);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: apply_setting(0, 1, 1, 1);            // low extremes
                    2: apply_setting(31, 32, 4096, 1);       // high extremes
                    3: apply_setting(7, 20, 0, 0);           // zero size: every offset equal
                    4: apply_setting(3, 32, $urandom_range(1, 4096), 0);
                    default: apply_setting($urandom_range(0, 31), $urandom_range(1, 32),
                                           $urandom_range(1, 4096), $urandom_range(0, 1));
                endcase
            end
            quota = items_sent + 55;
            while (items_sent < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    run_chain();
                else if (pick < 85)
                    send_item(1'b0, INDEX_W'($urandom), $urandom, $urandom);
                else if (pick < 93)
                    send_item(1'b1, INDEX_W'($urandom), $urandom, $urandom);
                else
                    send_item(1'b1, INDEX_W'($urandom), $urandom,
                              LINK_W'($urandom_range(0, 40)));
            end
        end

        settle();
        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("[sector_chain_walker] OK");
        else
            $display("[sector_chain_walker] ERROR");
        $finish;
    end

    // generous cap on the whole run
    initial begin
        #5_000_000;
        $display("[sector_chain_walker] ERROR");
        $finish;
    end

endmodule

// ----- sector_chain_walker.f -----
+incdir+hdl
hdl/scw_pkg.sv
hdl/scw_sector_check.sv
hdl/sector_chain_walker.sv
tb/sv/tb_sector_chain_walker.sv
